// ===== sv/tslf_pkg.sv =====
// shared types, character codes and defaults for the text stream line formatter
`default_nettype none
package tslf_pkg;

	// default width of the printed line number
	localparam int NUMBER_DIGITS_DEF = 6;
	// entries in the job queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CTRL_LIMIT   = 8'd32;
	localparam logic [7:0] CARET_OFFSET = 8'd64;

	typedef enum logic [2:0] {
		REG_NUMBER_LINES    = 3'd0,
		REG_NONBLANK_ONLY   = 3'd1,
		REG_COLLAPSE_BLANKS = 3'd2,
		REG_SHOW_ENDS       = 3'd3,
		REG_SHOW_TABS       = 3'd4,
		REG_SHOW_CONTROLS   = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       start_file;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	typedef struct packed {
		logic number_lines;
		logic nonblank_only;
		logic collapse_blanks;
		logic show_ends;
		logic show_tabs;
		logic show_controls;
	} cfg_regs_t;

	// one classified item: optional number prefix, then one or two body bytes
	typedef struct packed {
		logic       has_prefix;
		logic       pad;
		logic       pair;
		logic [7:0] b0;
		logic [7:0] b1;
	} job_t;

endpackage
`default_nettype wire

// ===== sv/tslf_front.sv =====
// front part: takes input bytes, tracks line state and classifies each byte into a job
`default_nettype none
module tslf_front #(
	parameter int NUMBER_DIGITS = tslf_pkg::NUMBER_DIGITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tslf_pkg::cfg_regs_t           cfg,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire tslf_pkg::in_item_t            in_data,
	input  wire logic                          q_full,
	output logic                               push,
	output tslf_pkg::job_t                     job,
	output logic [NUMBER_DIGITS-1:0][3:0]      digits
);

	logic [7:0]                     prev_q;
	logic [1:0]                     run_q;
	logic [NUMBER_DIGITS-1:0][3:0]  cnt_q;

	logic [7:0]                     b;
	logic [7:0]                     prev_eff;
	logic [1:0]                     run_eff;
	logic [1:0]                     run_new;
	logic [NUMBER_DIGITS-1:0][3:0]  cnt_eff;
	logic [NUMBER_DIGITS-1:0][3:0]  cnt_inc;
	logic                           carry;
	logic                           blank;
	logic                           squeezed;
	logic                           line_start;
	logic                           pad;
	logic                           accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign b        = in_data.in_byte;

	always_comb begin
		prev_eff = in_data.start_file ? tslf_pkg::CH_NL : prev_q;
		run_eff  = in_data.start_file ? 2'd0 : run_q;
		cnt_eff  = in_data.start_file ? '0 : cnt_q;
	end

	// bcd increment, stays at all nines
	always_comb begin
		cnt_inc = cnt_eff;
		carry   = 1'b1;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (carry) begin
				if (cnt_eff[i] == 4'd9) begin
					cnt_inc[i] = 4'd0;
				end else begin
					cnt_inc[i] = cnt_eff[i] + 4'd1;
					carry      = 1'b0;
				end
			end
		end
		if (carry) begin
			cnt_inc = cnt_eff;
		end
	end

	always_comb begin
		blank      = (b == tslf_pkg::CH_NL) && (prev_eff == tslf_pkg::CH_NL);
		run_new    = blank ? ((run_eff < 2'd2) ? run_eff + 2'd1 : 2'd2) : 2'd0;
		squeezed   = cfg.collapse_blanks && (run_new == 2'd2);
		line_start = cfg.number_lines && (prev_eff == tslf_pkg::CH_NL);
		pad        = cfg.nonblank_only && blank;
	end

	// body classification, tab rule first
	always_comb begin
		job.has_prefix = line_start;
		job.pad        = pad;
		job.pair       = 1'b1;
		job.b0         = tslf_pkg::CH_CARET;
		job.b1         = b;
		if (cfg.show_tabs && b == tslf_pkg::CH_TAB) begin
			job.b1 = tslf_pkg::CH_I;
		end else if (cfg.show_ends && b == tslf_pkg::CH_NL) begin
			job.b0 = tslf_pkg::CH_DOLLAR;
			job.b1 = tslf_pkg::CH_NL;
		end else if (cfg.show_controls && (b < tslf_pkg::CTRL_LIMIT || b[7])
				&& b != tslf_pkg::CH_NL && b != tslf_pkg::CH_TAB) begin
			job.b1 = b + tslf_pkg::CARET_OFFSET;
		end else if (cfg.show_controls && b == tslf_pkg::CH_DEL) begin
			job.b1 = tslf_pkg::CH_QUEST;
		end else begin
			job.pair = 1'b0;
			job.b0   = b;
		end
	end

	assign digits = cnt_inc;
	assign push   = accept && !squeezed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= tslf_pkg::CH_NL;
			run_q  <= 2'd0;
			cnt_q  <= '0;
		end else if (accept) begin
			run_q  <= run_new;
			prev_q <= squeezed ? prev_eff : b;
			if (!squeezed && line_start && !pad) begin
				cnt_q <= cnt_inc;
			end else begin
				cnt_q <= cnt_eff;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/tslf_queue.sv =====
// small job queue between front and back
`default_nettype none
module tslf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = tslf_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      head,
	output logic                  not_empty,
	output logic                  full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	logic [DEPTH-1:0][WIDTH-1:0] mem_q;
	logic [PW-1:0]               wr_q;
	logic [PW-1:0]               rd_q;
	logic [CW-1:0]               cnt_q;

	assign head      = mem_q[rd_q];
	assign not_empty = (cnt_q != '0);
	assign full      = (cnt_q == CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/tslf_back.sv =====
// back part: expands the head job into output bytes, one per cycle when not stalled
`default_nettype none
module tslf_back #(
	parameter int NUMBER_DIGITS = tslf_pkg::NUMBER_DIGITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tslf_pkg::job_t                job,
	input  wire logic [NUMBER_DIGITS-1:0][3:0] digits,
	input  wire logic                          q_not_empty,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output tslf_pkg::out_item_t                out_data
);

	localparam int PW = $clog2(NUMBER_DIGITS + 3);
	localparam int DW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
	localparam logic [PW-1:0] POS_TAB   = PW'(NUMBER_DIGITS);
	localparam logic [PW-1:0] POS_B0    = PW'(NUMBER_DIGITS + 1);
	localparam logic [PW-1:0] POS_B1    = PW'(NUMBER_DIGITS + 2);
	localparam logic [PW-1:0] POS_MSD   = PW'(NUMBER_DIGITS - 1);

	logic                active_q;
	logic [PW-1:0]       pos_q;
	logic                lead_q;
	logic                out_valid_q;
	tslf_pkg::out_item_t out_data_q;

	logic [PW-1:0]       cur_pos;
	logic [PW-1:0]       idx_full;
	logic [DW-1:0]       idx;
	logic [3:0]          d;
	logic                cur_lead;
	logic                lead_next;
	logic                is_digit;
	logic                is_last;
	logic [7:0]          byte_out;
	logic                load_ok;
	logic                emit;

	always_comb begin
		cur_pos   = active_q ? pos_q : (job.has_prefix ? '0 : POS_B0);
		cur_lead  = active_q ? lead_q : 1'b1;
		idx_full  = POS_MSD - cur_pos;
		idx       = idx_full[DW-1:0];
		d         = digits[idx];
		is_digit  = (cur_pos < POS_TAB);
		lead_next = cur_lead && (d == 4'd0) && (idx != '0);
		is_last   = (cur_pos == POS_B1) || (cur_pos == POS_B0 && !job.pair);
		if (is_digit) begin
			byte_out = (job.pad || lead_next) ? tslf_pkg::CH_SPACE
			                                  : tslf_pkg::CH_ZERO + {4'd0, d};
		end else if (cur_pos == POS_TAB) begin
			byte_out = tslf_pkg::CH_TAB;
		end else if (cur_pos == POS_B0) begin
			byte_out = job.b0;
		end else begin
			byte_out = job.b1;
		end
	end

	assign load_ok   = !out_valid_q || !out_stall;
	assign emit      = q_not_empty && load_ok;
	assign pop       = emit && is_last;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			pos_q       <= '0;
			lead_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (load_ok) begin
				out_valid_q <= q_not_empty;
			end
			if (emit) begin
				if (is_last) begin
					active_q <= 1'b0;
				end else begin
					active_q <= 1'b1;
					pos_q    <= cur_pos + 1'b1;
					if (is_digit) begin
						lead_q <= lead_next;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q.out_byte    <= byte_out;
			out_data_q.last_of_run <= is_last;
		end
	end

endmodule
`default_nettype wire

// ===== sv/text_stream_line_formatter.sv =====
// top level of the cat-style text stream line formatter
// with the queue empty, the first output byte of an item is registered in the job queue and
// then in the output register before it is valid
// throughput: one output byte per cycle when not stalled; a multi-byte item holds the back
// until its last byte; single-byte items flow at one per cycle, expansions stall the input
// reset: options cleared, previous byte newline, blank run and line counter zero, queue empty
`default_nettype none
module text_stream_line_formatter #(
	parameter int NUMBER_DIGITS = tslf_pkg::NUMBER_DIGITS_DEF,
	parameter int QUEUE_DEPTH   = tslf_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// input byte stream
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire tslf_pkg::in_item_t  in_data,
	// formatted output stream
	output logic                     out_valid,
	input  wire logic                out_stall,
	output tslf_pkg::out_item_t      out_data,
	// option register writes
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [2:0]          cfg_index,
	input  wire logic                cfg_data
);

	localparam int QW = NUMBER_DIGITS * 4 + $bits(tslf_pkg::job_t);

	tslf_pkg::cfg_regs_t           cfg_q;
	tslf_pkg::job_t                push_job;
	tslf_pkg::job_t                head_job;
	logic [NUMBER_DIGITS-1:0][3:0] push_digits;
	logic [NUMBER_DIGITS-1:0][3:0] head_digits;
	logic [QW-1:0]                 q_head;
	logic                          push;
	logic                          pop;
	logic                          q_full;
	logic                          q_not_empty;

	// option registers are always writable; writes to unused indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				tslf_pkg::REG_NUMBER_LINES:    cfg_q.number_lines    <= cfg_data;
				tslf_pkg::REG_NONBLANK_ONLY:   cfg_q.nonblank_only   <= cfg_data;
				tslf_pkg::REG_COLLAPSE_BLANKS: cfg_q.collapse_blanks <= cfg_data;
				tslf_pkg::REG_SHOW_ENDS:       cfg_q.show_ends       <= cfg_data;
				tslf_pkg::REG_SHOW_TABS:       cfg_q.show_tabs       <= cfg_data;
				tslf_pkg::REG_SHOW_CONTROLS:   cfg_q.show_controls   <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: line state, counter and byte classification, one transaction per cycle if room
	tslf_front #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.job      (push_job),
		.digits   (push_digits)
	);

	// queue decouples classification from byte expansion; squeezed lines never enter it
	tslf_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_digits, push_job}),
		.pop       (pop),
		.head      (q_head),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	assign head_job    = q_head[$bits(tslf_pkg::job_t)-1:0];
	assign head_digits = q_head[QW-1:$bits(tslf_pkg::job_t)];

	// back: number prefix then body bytes, into the output register
	tslf_back #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (head_job),
		.digits      (head_digits),
		.q_not_empty (q_not_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule
`default_nettype wire

// ===== sv/tslf_checker.sv =====
// port-level assertions for the text stream line formatter, bound to the top level
`default_nettype none
module tslf_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire tslf_pkg::out_item_t out_data
);

	// a stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// an expansion runs without gaps once its first byte is taken
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last_of_run |=> out_valid)
		else $error("gap inside an expansion");

	// the queue fills only behind a pending output byte
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with nothing on the output");

	// an edge seen in reset leaves the datapath empty
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !in_stall && !out_valid)
		else $error("not idle after reset");

endmodule

bind text_stream_line_formatter tslf_checker u_tslf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
`default_nettype wire
